// ----- rtl/core/stt_pkg.sv -----
// Package for the software timer table: request codes, result kinds, sizes.
package stt_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned IDX_W = 5;
	localparam logic [15:0] RSV_EVT_RESET = 16'hFFFF;

	typedef enum logic [3:0] {
		REQ_TICK = 4'd0, REQ_NEW_PER = 4'd1, REQ_NEW_ONE = 4'd2, REQ_UPD_PER = 4'd3,
		REQ_UPD_ONE = 4'd4, REQ_RES_PER = 4'd5, REQ_FREE = 4'd6, REQ_FREE_OWN = 4'd7,
		REQ_PAUSE = 4'd8, REQ_RESUME = 4'd9, REQ_READ = 4'd10, REQ_UPDATE = 4'd11
	} req_t;

	typedef enum logic [1:0] {
		KIND_EVENT = 2'd0, KIND_CALLBACK = 2'd1, KIND_TICK_DONE = 2'd2, KIND_REQ_DONE = 2'd3
	} kind_t;
endpackage

// ----- rtl/core/software_timer_table_core.sv -----
// Top level of the software timer table: slot store, sweep sequencer, APB register.
//
// Usage:
//  Slave stream s_axis_* carries one request: req_type on tuser, owner_id,
//  event_code and timeout_ticks on tdata. Master stream m_axis_* returns results:
//  result_kind on tuser, out_owner, out_event, slot_index, remaining on tdata,
//  last_result on tlast. APB register 0 (address 0) holds the reserved event code.
//
// Timing:
//  One request at a time. A tick sweeps all slots through a single
//  compare/decrement unit, one slot per cycle unless an expiry waits on the
//  master side, emitting an expiry per firing slot and then a tick-done result.
//  New requests do only a free-slot sweep; other requests do one lookup sweep
//  and, for the or-new forms on a miss, a free-slot sweep, then one write and
//  one result. Every sweep steps through the slots on the shared pointer.
//
// Reset clears valid/enable bits and the sequencer; slot payload memories
// are not reset. When the master side stalls, the sweep holds until the waiting
// result is taken, then moves past the firing slot; s_axis_tready is low throughout.
module software_timer_table_core
	import stt_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tuser: req_type[3:0]
	input  logic [3:0]  s_axis_tuser,
	// tdata: owner_id[7:0], event_code[23:8], timeout_ticks[55:24]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tuser: result_kind[1:0]
	output logic [1:0]  m_axis_tuser,
	// tdata: out_owner[7:0], out_event[23:8], slot_index[28:24], remaining[60:29],
	// zeros
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned SW = $clog2(SLOTS + 1);
	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SW-1:0] NONE = SW'(SLOTS);

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_FREE, S_WRITE, S_TICK, S_OUT} state_t;

	state_t state_q;
	logic [15:0] rsv_q;
	logic [SLOTS-1:0] valid_q, en_q;
	logic [31:0] reload_mem [SLOTS];
	logic [31:0] count_mem  [SLOTS];
	logic [15:0] event_mem  [SLOTS];
	logic [7:0]  owner_mem  [SLOTS];

	logic [3:0]  req_q;
	logic [7:0]  own_q;
	logic [15:0] ev_q;
	logic [31:0] tmo_q;
	logic [SW-1:0] ptr_q, hit_q;
	logic tick_done_q, look_done_q;
	logic [1:0]  o_kind_q;
	logic [7:0]  o_own_q;
	logic [15:0] o_ev_q;
	logic [SW-1:0] o_idx_q;
	logic [31:0] o_rem_q;
	logic o_last_q;

	logic [AW-1:0] pa;
	logic [31:0] rd_count, rd_reload, loadv;
	logic [15:0] rd_ev;
	logic [7:0] rd_own;
	logic match, own_match, periodic, load_slot;

	assign pa = ptr_q[AW-1:0];
	assign rd_count = count_mem[pa];
	assign rd_reload = reload_mem[pa];
	assign rd_ev = event_mem[pa];
	assign rd_own = owner_mem[pa];
	assign own_match = valid_q[pa] && rd_own == own_q;
	assign match = own_match && rd_ev == ev_q;
	assign loadv = (tmo_q != 32'd0) ? tmo_q - 32'd1 : 32'd0;
	assign periodic = req_q != REQ_NEW_ONE && req_q != REQ_UPD_ONE;
	// payload is loaded by allocations and updates; resume-or-new only when it allocated
	assign load_slot = req_q == REQ_NEW_PER || req_q == REQ_NEW_ONE ||
		req_q == REQ_UPD_PER || req_q == REQ_UPD_ONE || req_q == REQ_UPDATE ||
		(req_q == REQ_RES_PER && !look_done_q);

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, rsv_q} : 32'd0;
	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = state_q == S_OUT;
	assign m_axis_tlast = o_last_q;
	assign m_axis_tuser = o_kind_q;
	assign m_axis_tdata = {3'b000, o_rem_q, IDX_W'(o_idx_q), o_ev_q, o_own_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_q <= RSV_EVT_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			rsv_q <= pwdata[15:0];
		end
	end

	// slot payload memories: count written at the sweep pointer on a tick, all at the hit slot on a load
	always_ff @(posedge clk) begin
		if (state_q == S_TICK && !tick_done_q && valid_q[pa] && en_q[pa]) begin
			count_mem[pa] <= (rd_count == 32'd0) ? rd_reload : rd_count - 32'd1;
		end else if (state_q == S_WRITE && hit_q != NONE && load_slot) begin
			count_mem[hit_q[AW-1:0]] <= loadv;
			reload_mem[hit_q[AW-1:0]] <= periodic || look_done_q ? loadv : 32'd0;
			owner_mem[hit_q[AW-1:0]] <= own_q;
			event_mem[hit_q[AW-1:0]] <= ev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			en_q <= '0;
			ptr_q <= '0;
			hit_q <= '0;
			tick_done_q <= 1'b0;
			look_done_q <= 1'b0;
			o_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q <= s_axis_tuser;
						own_q <= s_axis_tdata[7:0];
						ev_q <= s_axis_tdata[23:8];
						tmo_q <= s_axis_tdata[55:24];
						ptr_q <= '0;
						hit_q <= NONE;
						look_done_q <= 1'b0;
						tick_done_q <= 1'b0;
						priority if (s_axis_tuser == REQ_TICK) state_q <= S_TICK;
						else if (s_axis_tuser == REQ_NEW_PER ||
							s_axis_tuser == REQ_NEW_ONE) state_q <= S_FREE;
						else if (s_axis_tuser > REQ_UPDATE) state_q <= S_WRITE;
						else state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// lowest match; free-owner frees as it goes
					if (req_q == REQ_FREE_OWN) begin
						if (own_match) begin
							valid_q[pa] <= 1'b0;
							en_q[pa] <= 1'b0;
							if (hit_q == NONE) hit_q <= ptr_q;
						end
					end else if (match && hit_q == NONE) begin
						hit_q <= ptr_q;
					end
					if (ptr_q == NONE - SW'(1)) begin
						ptr_q <= '0;
						look_done_q <= 1'b1;
						if (req_q == REQ_FREE_OWN) state_q <= S_WRITE;
						else if (!(match && hit_q == NONE) && hit_q == NONE &&
							(req_q == REQ_UPD_PER || req_q == REQ_UPD_ONE ||
							 req_q == REQ_RES_PER)) state_q <= S_FREE;
						else state_q <= S_WRITE;
					end else begin
						ptr_q <= ptr_q + SW'(1);
					end
				end
				S_FREE: begin
					look_done_q <= 1'b0;
					if (!valid_q[pa]) begin
						hit_q <= ptr_q;
						state_q <= S_WRITE;
					end else if (ptr_q == NONE - SW'(1)) begin
						hit_q <= NONE;
						state_q <= S_WRITE;
					end else begin
						ptr_q <= ptr_q + SW'(1);
					end
				end
				S_WRITE: begin
					// look_done_q high: hit came from lookup
					if (hit_q != NONE) begin
						unique case (req_q)
							REQ_NEW_PER, REQ_NEW_ONE, REQ_UPD_PER, REQ_UPD_ONE,
							REQ_UPDATE: begin
								valid_q[hit_q[AW-1:0]] <= 1'b1;
								en_q[hit_q[AW-1:0]] <= 1'b1;
							end
							REQ_RES_PER, REQ_RESUME: begin
								valid_q[hit_q[AW-1:0]] <= 1'b1;
								en_q[hit_q[AW-1:0]] <= 1'b1;
							end
							REQ_FREE: begin
								valid_q[hit_q[AW-1:0]] <= 1'b0;
								en_q[hit_q[AW-1:0]] <= 1'b0;
							end
							REQ_PAUSE: en_q[hit_q[AW-1:0]] <= 1'b0;
							default: ;
						endcase
					end
					o_kind_q <= KIND_REQ_DONE;
					o_own_q <= '0;
					o_ev_q <= '0;
					o_idx_q <= (req_q > REQ_UPDATE) ? NONE : hit_q;
					o_rem_q <= (req_q == REQ_READ && hit_q != NONE) ?
						count_mem[hit_q[AW-1:0]] : 32'd0;
					o_last_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_TICK: begin
					if (tick_done_q) begin
						o_kind_q <= KIND_TICK_DONE;
						o_own_q <= '0;
						o_ev_q <= '0;
						o_idx_q <= NONE;
						o_rem_q <= '0;
						o_last_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						if (valid_q[pa] && en_q[pa] && rd_count == 32'd0) begin
							o_kind_q <= (rd_ev == rsv_q) ? KIND_CALLBACK : KIND_EVENT;
							o_own_q <= rd_own;
							o_ev_q <= rd_ev;
							o_idx_q <= ptr_q;
							o_rem_q <= '0;
							o_last_q <= 1'b0;
							state_q <= S_OUT;
							if (rd_reload == 32'd0) begin
								valid_q[pa] <= 1'b0;
								en_q[pa] <= 1'b0;
							end
						end
						if (ptr_q == NONE - SW'(1)) tick_done_q <= 1'b1;
						else ptr_q <= ptr_q + SW'(1);
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						if (o_last_q) state_q <= S_IDLE;
						else state_q <= S_TICK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/stt_checker.sv -----
// Port-level checks for the software timer table, bound to the top level.
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [1:0]  m_axis_tuser,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	// no new request while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("output dropped");
	// done kinds are always last, expiries never
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[1])) else $error("tlast kind");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
endmodule

bind software_timer_table_core stt_checker u_stt_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
